@@ design/ftpd_pkg.sv @@
// Shared types and constants for the file transfer packet deframer.
package ftpd_pkg;

    localparam int unsigned POS_W    = 17;
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned FIELD_W  = 16;

    localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

    // Byte positions inside a packet (1-based)
    localparam logic [POS_W-1:0] POS_OP_HI  = POS_W'(1);
    localparam logic [POS_W-1:0] POS_OP_LO  = POS_W'(2);
    localparam logic [POS_W-1:0] POS_F1_HI  = POS_W'(3);
    localparam logic [POS_W-1:0] POS_F1_LO  = POS_W'(4);
    localparam logic [POS_W-1:0] POS_F2_HI  = POS_W'(5);
    localparam logic [POS_W-1:0] POS_F2_LO  = POS_W'(6);
    localparam logic [POS_W-1:0] DATA_HDR_LEN = POS_W'(6);

    // Opcodes
    localparam logic [FIELD_W-1:0] OP_DATA  = FIELD_W'(3);
    localparam logic [FIELD_W-1:0] OP_ACK   = FIELD_W'(4);
    localparam logic [FIELD_W-1:0] OP_ERROR = FIELD_W'(5);
    localparam logic [FIELD_W-1:0] OP_BCAST = FIELD_W'(9);

    typedef enum logic [1:0] {
        KIND_ACK   = 2'd0,
        KIND_DATA  = 2'd1,
        KIND_ERROR = 2'd2,
        KIND_BCAST = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t               kind;
        logic [FIELD_W-1:0]  block_number;
        logic [FIELD_W-1:0]  error_code;
        logic [FIELD_W-1:0]  data_size;
        logic [BYTE_W-1:0]   event_byte;
        logic [BYTE_W-1:0]   payload_byte;
        logic                payload_valid;
        logic                last;
    } result_t;

endpackage

@@ design/ftpd_parser.sv @@
// Packet state registers and per-byte decode of the deframer.
module ftpd_parser (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          advance,
    input  logic [ftpd_pkg::BYTE_W-1:0]   rx_byte,
    output logic                          has_result,
    output ftpd_pkg::result_t             result
);

    logic [ftpd_pkg::POS_W-1:0]   pos_reg,    pos_next;
    logic [ftpd_pkg::FIELD_W-1:0] opcode_reg, opcode_next;
    logic [ftpd_pkg::BYTE_W-1:0]  pend_reg,   pend_next;
    logic [ftpd_pkg::FIELD_W-1:0] size_reg,   size_next;
    logic [ftpd_pkg::FIELD_W-1:0] block_reg,  block_next;
    logic [ftpd_pkg::FIELD_W-1:0] code_reg,   code_next;
    logic [ftpd_pkg::BYTE_W-1:0]  event_reg,  event_next;

    logic [ftpd_pkg::POS_W-1:0]   pos_inc;
    logic [ftpd_pkg::FIELD_W-1:0] word;
    logic                         done;
    logic                         emit;
    ftpd_pkg::kind_t              kind;
    logic                         pvalid;
    logic                         is_zero;

    always_comb begin
        pos_inc = pos_reg + ((pos_reg != ftpd_pkg::POS_MAX) ? ftpd_pkg::POS_W'(1)
                                                           : ftpd_pkg::POS_W'(0));
        word    = {pend_reg, rx_byte};
        is_zero = (rx_byte == '0);

        opcode_next = opcode_reg;
        pend_next   = pend_reg;
        size_next   = size_reg;
        block_next  = block_reg;
        code_next   = code_reg;
        event_next  = event_reg;
        done        = 1'b0;
        emit        = 1'b0;
        kind        = ftpd_pkg::KIND_ACK;
        pvalid      = 1'b0;

        priority if (pos_inc == ftpd_pkg::POS_OP_HI) begin
            pend_next = rx_byte;
        end else if (pos_inc == ftpd_pkg::POS_OP_LO) begin
            opcode_next = word;
        end else if (opcode_reg == ftpd_pkg::OP_ACK) begin
            if (pos_inc == ftpd_pkg::POS_F1_HI) begin
                pend_next = rx_byte;
            end else if (pos_inc == ftpd_pkg::POS_F1_LO) begin
                block_next = word;
                emit       = 1'b1;
                done       = 1'b1;
                kind       = ftpd_pkg::KIND_ACK;
            end
        end else if (opcode_reg == ftpd_pkg::OP_ERROR) begin
            kind = ftpd_pkg::KIND_ERROR;
            if (pos_inc == ftpd_pkg::POS_F1_HI) begin
                pend_next = rx_byte;
            end else if (pos_inc == ftpd_pkg::POS_F1_LO) begin
                code_next = word;
            end else begin
                // message byte or terminator
                emit   = 1'b1;
                done   = is_zero;
                pvalid = !is_zero;
            end
        end else if (opcode_reg == ftpd_pkg::OP_DATA) begin
            kind = ftpd_pkg::KIND_DATA;
            if (pos_inc == ftpd_pkg::POS_F1_HI || pos_inc == ftpd_pkg::POS_F2_HI) begin
                pend_next = rx_byte;
            end else if (pos_inc == ftpd_pkg::POS_F1_LO) begin
                size_next = word;
            end else if (pos_inc == ftpd_pkg::POS_F2_LO) begin
                block_next = word;
                if (size_reg == '0) begin
                    // empty payload: header closes the packet
                    emit = 1'b1;
                    done = 1'b1;
                end
            end else begin
                emit   = 1'b1;
                pvalid = 1'b1;
                done   = ((pos_inc - ftpd_pkg::DATA_HDR_LEN) >=
                          {1'b0, size_reg});
            end
        end else if (opcode_reg == ftpd_pkg::OP_BCAST) begin
            kind = ftpd_pkg::KIND_BCAST;
            if (pos_inc == ftpd_pkg::POS_F1_HI) begin
                event_next = rx_byte;
            end else begin
                emit   = 1'b1;
                done   = is_zero;
                pvalid = !is_zero;
            end
        end else begin
            // unknown opcode: bytes are swallowed until reset
        end

        pos_next = done ? '0 : pos_inc;

        has_result           = emit;
        result.kind          = kind;
        result.block_number  = (kind == ftpd_pkg::KIND_ACK || kind == ftpd_pkg::KIND_DATA)
                               ? block_next : '0;
        result.error_code    = (kind == ftpd_pkg::KIND_ERROR) ? code_next : '0;
        result.data_size     = (kind == ftpd_pkg::KIND_DATA) ? size_next : '0;
        result.event_byte    = (kind == ftpd_pkg::KIND_BCAST) ? event_next : '0;
        result.payload_byte  = pvalid ? rx_byte : '0;
        result.payload_valid = pvalid;
        result.last          = done;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg    <= '0;
            opcode_reg <= '0;
            pend_reg   <= '0;
            size_reg   <= '0;
            block_reg  <= '0;
            code_reg   <= '0;
            event_reg  <= '0;
        end else if (advance) begin
            pos_reg    <= pos_next;
            opcode_reg <= opcode_next;
            pend_reg   <= pend_next;
            size_reg   <= size_next;
            block_reg  <= block_next;
            code_reg   <= code_next;
            event_reg  <= event_next;
        end
    end

endmodule

@@ design/ftpd_out_reg.sv @@
// Result output register with valid/ready handshake.
module ftpd_out_reg (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               load,
    input  ftpd_pkg::result_t  result_in,
    output logic               free,
    output logic               m_valid,
    input  logic               m_ready,
    output ftpd_pkg::result_t  result_out
);

    logic              valid_reg, valid_next;
    ftpd_pkg::result_t data_reg;

    assign free       = !valid_reg || m_ready;
    assign m_valid    = valid_reg;
    assign result_out = data_reg;

    always_comb begin
        if (load) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= result_in;
        end
    end

endmodule

@@ design/file_transfer_packet_deframer_core.sv @@
// Top level of the file transfer packet deframer.
//
//  Channel   Ports                          Direction  Carries
//  s_        s_valid s_ready s_rx_byte      in         one received byte per word
//  m_        m_valid m_ready m_kind ...     out        zero or one result per byte
//
//  Each byte is decoded in the cycle it is accepted; its result, if any, is
//  in the output register in the next cycle. Throughput is one byte per cycle
//  while s_ready is high. s_ready is high whenever the output register is
//  empty or being drained, so a stalled m_ready holds off input only while
//  a result is waiting. aresetn is synchronous, active low; it clears the
//  packet state and the output valid flag.
module file_transfer_packet_deframer_core (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_kind,
    output logic [15:0] m_block_number,
    output logic [15:0] m_error_code,
    output logic [15:0] m_data_size,
    output logic [7:0]  m_event_byte,
    output logic [7:0]  m_payload_byte,
    output logic        m_payload_valid,
    output logic        m_last
);

    logic              accept;
    logic              has_result;
    logic              out_free;
    ftpd_pkg::result_t result;
    ftpd_pkg::result_t result_q;

    // input word taken whenever the result slot can absorb it
    assign s_ready = out_free;
    assign accept  = s_valid && out_free;

    ftpd_parser u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .advance    (accept),
        .rx_byte    (s_rx_byte),
        .has_result (has_result),
        .result     (result)
    );

    ftpd_out_reg u_out (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (accept && has_result),
        .result_in  (result),
        .free       (out_free),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .result_out (result_q)
    );

    assign m_kind          = result_q.kind;
    assign m_block_number  = result_q.block_number;
    assign m_error_code    = result_q.error_code;
    assign m_data_size     = result_q.data_size;
    assign m_event_byte    = result_q.event_byte;
    assign m_payload_byte  = result_q.payload_byte;
    assign m_payload_valid = result_q.payload_valid;
    assign m_last          = result_q.last;

endmodule
